// File: src/fcgi_pkg.sv
// Shared constants and codes for the FastCGI record deframer.
package fcgi_pkg;

  localparam int BYTE_W   = 8;
  localparam int IDENT_W  = 16;
  localparam int LEN_W    = 16;
  localparam int KIND_W   = 2;
  localparam int PHASE_W  = 2;
  localparam int HDR_CNT_W = 3;
  localparam int OUT_W    = BYTE_W + IDENT_W;

  // Header byte positions
  localparam logic [HDR_CNT_W-1:0] HDR_TYPE     = 3'd1;
  localparam logic [HDR_CNT_W-1:0] HDR_ID_HI    = 3'd2;
  localparam logic [HDR_CNT_W-1:0] HDR_ID_LO    = 3'd3;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI   = 3'd4;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_LO   = 3'd5;
  localparam logic [HDR_CNT_W-1:0] HDR_PAD      = 3'd6;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST     = 3'd7;

  localparam logic [PHASE_W-1:0] PHASE_HEADER  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CONTENT = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_PADDING = 2'd2;

  localparam logic [BYTE_W-1:0] TYPE_END_REQUEST = 8'd3;
  localparam logic [BYTE_W-1:0] TYPE_STDOUT      = 8'd6;
  localparam logic [BYTE_W-1:0] TYPE_STDERR      = 8'd7;

  localparam logic [KIND_W-1:0] KIND_STDOUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STDERR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_OK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END_FAIL = 2'd3;

endpackage

// File: src/fastcgi_record_deframer_top.sv
// FastCGI record deframer: splits responder bytes into tagged stream beats.
//
//   channel  dir  beat contents
//   s_axis   in   tdata[7:0] received byte
//   m_axis   out  tdata {request id, data byte}, tuser kind, tlast record end
//
// One byte per cycle sustained unless the output stalls. A byte is registered on acceptance and decoded
// into the result register once the result register can advance.
// s_axis_tready drops only while both the input and result registers are full
// and m_axis_tready is low. rst (synchronous) returns to the header phase and
// clears the end-of-response flag.
module fastcgi_record_deframer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [fcgi_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [fcgi_pkg::OUT_W-1:0]  m_axis_tdata,   // [7:0] data_byte, [23:8] request_ident
  output logic                        m_axis_tlast,   // last_of_record
  output logic [fcgi_pkg::KIND_W-1:0] m_axis_tuser    // [1:0] out_kind
);
  import fcgi_pkg::*;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // record state
  logic [PHASE_W-1:0]   phase, phase_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [BYTE_W-1:0]    record_type, record_type_next;
  logic [IDENT_W-1:0]   record_ident, record_ident_next;
  logic [LEN_W-1:0]     content_length, content_length_next;
  logic [BYTE_W-1:0]    padding_length, padding_length_next;
  logic [LEN_W-1:0]     bytes_left, bytes_left_next;
  logic                 finished, finished_next;

  // result register
  logic               out_valid;
  logic [KIND_W-1:0]  out_kind;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic [IDENT_W-1:0] out_ident;

  logic               emit;
  logic [KIND_W-1:0]  emit_kind;
  logic [BYTE_W-1:0]  emit_byte;
  logic               emit_last;

  logic advance;
  logic process;
  logic [LEN_W-1:0] left_dec;

  assign advance       = !out_valid || m_axis_tready;
  assign process       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign left_dec      = bytes_left - LEN_W'(1);

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    record_type_next    = record_type;
    record_ident_next   = record_ident;
    content_length_next = content_length;
    padding_length_next = padding_length;
    bytes_left_next     = bytes_left;
    finished_next       = finished;
    emit      = 1'b0;
    emit_kind = KIND_STDOUT;
    emit_byte = '0;
    emit_last = 1'b0;

    if (!finished) begin
      if (phase == PHASE_CONTENT) begin
        if (record_type == TYPE_STDOUT || record_type == TYPE_STDERR) begin
          emit      = 1'b1;
          emit_kind = (record_type == TYPE_STDOUT) ? KIND_STDOUT : KIND_STDERR;
          emit_byte = in_byte;
          emit_last = (bytes_left == LEN_W'(1));
        end
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          if (padding_length != '0) begin
            phase_next      = PHASE_PADDING;
            bytes_left_next = LEN_W'(padding_length);
          end else begin
            phase_next      = PHASE_HEADER;
            bytes_left_next = '0;
          end
        end
      end else if (phase == PHASE_PADDING) begin
        bytes_left_next = left_dec;
        if (left_dec == '0) phase_next = PHASE_HEADER;
      end else begin
        // header phase, also the unused phase code
        phase_next = PHASE_HEADER;
        unique case (header_count)
          HDR_TYPE:   record_type_next = in_byte;
          HDR_ID_HI:  record_ident_next = {in_byte, record_ident[BYTE_W-1:0]};
          HDR_ID_LO:  record_ident_next = {record_ident[IDENT_W-1:BYTE_W], in_byte};
          HDR_LEN_HI: content_length_next = {in_byte, content_length[BYTE_W-1:0]};
          HDR_LEN_LO: content_length_next = {content_length[LEN_W-1:BYTE_W], in_byte};
          HDR_PAD:    padding_length_next = in_byte;
          default:    ;
        endcase
        if (header_count != HDR_LAST) begin
          header_count_next = header_count + HDR_CNT_W'(1);
        end else begin
          header_count_next = '0;
          // zero length wins over the end-request type
          if (content_length == '0) begin
            finished_next = 1'b1;
            emit          = 1'b1;
            emit_kind     = KIND_END_FAIL;
          end else if (record_type == TYPE_END_REQUEST) begin
            finished_next = 1'b1;
            emit          = 1'b1;
            emit_kind     = KIND_END_OK;
          end else begin
            phase_next      = PHASE_CONTENT;
            bytes_left_next = content_length;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      phase          <= PHASE_HEADER;
      header_count   <= '0;
      record_type    <= '0;
      record_ident   <= '0;
      content_length <= '0;
      padding_length <= '0;
      bytes_left     <= '0;
      finished       <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (process) begin
        in_valid <= 1'b0;
      end

      if (advance) out_valid <= process && emit;

      if (process) begin
        phase          <= phase_next;
        header_count   <= header_count_next;
        record_type    <= record_type_next;
        record_ident   <= record_ident_next;
        content_length <= content_length_next;
        padding_length <= padding_length_next;
        bytes_left     <= bytes_left_next;
        finished       <= finished_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_byte <= s_axis_tdata;
    if (process && emit) begin
      out_kind  <= emit_kind;
      out_byte  <= emit_byte;
      out_last  <= emit_last;
      out_ident <= record_ident_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_ident, out_byte};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_kind;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the FastCGI record deframer top level.
module testbench;
  import fcgi_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int TARGET_BYTES = 1850;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [IDENT_W-1:0] ident;
  } out_beat_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BYTE_W-1:0]   s_axis_tdata  = '0;  // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;        // [7:0] data_byte, [23:8] request_ident
  logic                m_axis_tlast;        // last_of_record
  logic [KIND_W-1:0]   m_axis_tuser;        // [1:0] out_kind

  // deframer state as predicted from the accepted byte stream
  logic [PHASE_W-1:0]   dphase;
  logic [HDR_CNT_W-1:0] hdr_cnt;
  logic [BYTE_W-1:0]    rec_type;
  logic [IDENT_W-1:0]   rec_ident;
  logic [LEN_W-1:0]     content_len;
  logic [BYTE_W-1:0]    pad_len;
  logic [LEN_W-1:0]     remaining;
  logic                 resp_done;

  logic [BYTE_W-1:0] stream_bytes[$];
  out_beat_t         expected_beats[$];
  int unsigned       planned_results = 0;
  int unsigned       rx_count        = 0;
  int                mismatch_count  = 0;
  int                quiet_cycles    = 0;

  fastcgi_record_deframer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Returns 1 when the byte produces an output beat.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output out_beat_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    if (resp_done) return 1'b0;
    case (dphase)
      PHASE_CONTENT: begin
        if (rec_type == TYPE_STDOUT || rec_type == TYPE_STDERR) begin
          r.kind  = (rec_type == TYPE_STDOUT) ? KIND_STDOUT : KIND_STDERR;
          r.data  = b;
          r.last  = (remaining == LEN_W'(1));
          r.ident = rec_ident;
          hit     = 1'b1;
        end
        remaining = remaining - LEN_W'(1);
        if (remaining == '0) begin
          if (pad_len != '0) begin
            dphase    = PHASE_PADDING;
            remaining = {8'd0, pad_len};
          end else begin
            dphase = PHASE_HEADER;
          end
        end
      end
      PHASE_PADDING: begin
        remaining = remaining - LEN_W'(1);
        if (remaining == '0) dphase = PHASE_HEADER;
      end
      default: begin
        // header phase, also the unused phase code
        dphase = PHASE_HEADER;
        case (hdr_cnt)
          HDR_TYPE:   rec_type          = b;
          HDR_ID_HI:  rec_ident[15:8]   = b;
          HDR_ID_LO:  rec_ident[7:0]    = b;
          HDR_LEN_HI: content_len[15:8] = b;
          HDR_LEN_LO: content_len[7:0]  = b;
          HDR_PAD:    pad_len           = b;
          default: ;
        endcase
        if (hdr_cnt != HDR_LAST) begin
          hdr_cnt = hdr_cnt + HDR_CNT_W'(1);
        end else begin
          hdr_cnt = '0;
          if (content_len == '0) begin
            // zero length wins over the type, end-request included
            resp_done = 1'b1;
            r.kind    = KIND_END_FAIL;
            r.ident   = rec_ident;
            hit       = 1'b1;
          end else if (rec_type == TYPE_END_REQUEST) begin
            resp_done = 1'b1;
            r.kind    = KIND_END_OK;
            r.ident   = rec_ident;
            hit       = 1'b1;
          end else begin
            dphase    = PHASE_CONTENT;
            remaining = content_len;
          end
        end
      end
    endcase
    return hit;
  endfunction

  // Queues one record: header, then content and padding unless it ends the response.
  task automatic add_record(input logic [BYTE_W-1:0] rtype, input logic [IDENT_W-1:0] ident,
                            input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] pad);
    stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));  // version
    stream_bytes.push_back(rtype);
    stream_bytes.push_back(ident[15:8]);
    stream_bytes.push_back(ident[7:0]);
    stream_bytes.push_back(len[15:8]);
    stream_bytes.push_back(len[7:0]);
    stream_bytes.push_back(pad);
    stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));  // reserved
    if (len != '0 && rtype != TYPE_END_REQUEST) begin
      for (int i = 0; i < int'(len); i++)
        stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      for (int i = 0; i < int'(pad); i++)
        stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      if (rtype == TYPE_STDOUT || rtype == TYPE_STDERR) planned_results += 32'(len);
    end
  endtask

  // Idle percentage by run phase: 0 sender light / receiver heavy, 1 swapped, 2 none.
  function automatic int idle_pct(input bit sender);
    int unsigned mode;
    mode = (rx_count * 3) / planned_results;
    case (mode)
      0:       return sender ? 15 : 80;
      1:       return sender ? 80 : 15;
      default: return 0;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stream_bytes.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
  end

  always @(posedge clk) begin : check_beats
    out_beat_t want;
    out_beat_t got;
    if (rst) begin
      dphase      = PHASE_HEADER;
      hdr_cnt     = '0;
      rec_type    = '0;
      rec_ident   = '0;
      content_len = '0;
      pad_len     = '0;
      remaining   = '0;
      resp_done   = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (deframe_byte(s_axis_tdata, want)) expected_beats.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: m_axis_tuser, data: m_axis_tdata[7:0], last: m_axis_tlast,
                ident: m_axis_tdata[23:8]};
        rx_count++;
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: kind %0d data %0h ident %0h", got.kind, got.data,
                 got.ident);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          compare_field("out_kind", 16'(want.kind), 16'(got.kind));
          compare_field("data_byte", 16'(want.data), 16'(got.data));
          compare_field("last_of_record", 16'(want.last), 16'(got.last));
          compare_field("request_ident", want.ident, got.ident);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned       roll;
    logic [BYTE_W-1:0] rtype;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] pad;

    // directed records
    add_record(TYPE_STDOUT, 16'hFFFF, 16'd1, 8'd0);        // one-byte record
    add_record(TYPE_STDERR, 16'h0000, 16'd2, 8'hFF);       // longest padding
    add_record(8'hFF, 16'h5AA5, 16'd3, 8'd1);              // unknown type, skipped
    add_record(TYPE_STDOUT, 16'h1234, 16'h0100, 8'd0);     // length low byte zero
    add_record(8'h00, 16'hA55A, 16'h0180, 8'h10);          // long record, skipped
    add_record(TYPE_STDERR, 16'h00FF, 16'd1, 8'd3);

    // random well-formed records up to the stream size; most carry stream data
    while (stream_bytes.size() < TARGET_BYTES) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) rtype = TYPE_STDOUT;
      else if (roll < 75) rtype = TYPE_STDERR;
      else begin
        rtype = BYTE_W'($urandom_range(0, 255));
        if (rtype == TYPE_END_REQUEST) rtype = 8'h00;
      end
      len = ($urandom_range(0, 99) < 90) ? LEN_W'($urandom_range(1, 16))
                                          : LEN_W'($urandom_range(17, 300));
      pad = ($urandom_range(0, 99) < 80) ? BYTE_W'($urandom_range(0, 7))
                                          : BYTE_W'($urandom_range(0, 255));
      add_record(rtype, IDENT_W'($urandom_range(0, 16'hFFFF)), len, pad);
    end

    // the response can end only once per run
    case ($urandom_range(0, 2))
      0: add_record(TYPE_END_REQUEST, IDENT_W'($urandom_range(0, 16'hFFFF)),
                    LEN_W'($urandom_range(1, 16'hFFFF)), BYTE_W'($urandom_range(0, 255)));
      1: add_record(TYPE_STDOUT, IDENT_W'($urandom_range(0, 16'hFFFF)), 16'd0,
                    BYTE_W'($urandom_range(0, 255)));
      default: add_record(TYPE_END_REQUEST, IDENT_W'($urandom_range(0, 16'hFFFF)), 16'd0,
                          BYTE_W'($urandom_range(0, 255)));
    endcase
    // bytes after the end must be dropped
    repeat (32) stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (stream_bytes.size() != 0 || s_axis_tvalid || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_beats.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: fastcgi_record_deframer_top.f
src/fcgi_pkg.sv
src/fastcgi_record_deframer_top.sv
tb/testbench.sv
